/* src/v2d_pkg.sv */
// ----------------------------------------------------------------------------
// v2d_pkg
// Shared constants, operation codes and helpers for the 2D vector unit.
// ----------------------------------------------------------------------------
package v2d_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int MAG_W   = 17;            // isqrt of up to 2^31
  localparam int SQ_W    = 32;            // a_x^2 + a_y^2
  localparam int ISQ_STEPS = 16;          // result bits of the root, one per input bit pair
  localparam int DIV_W   = 16;            // quotient magnitude bits

  localparam logic [2:0] OP_MAG = 3'd0;
  localparam logic [2:0] OP_DOT = 3'd1;
  localparam logic [2:0] OP_PAR = 3'd2;
  localparam logic [2:0] OP_ORT = 3'd3;
  localparam logic [2:0] OP_ADD = 3'd4;
  localparam logic [2:0] OP_MUL = 3'd5;

  localparam logic [1:0] TURN_RIGHT = 2'd0;
  localparam logic [1:0] TURN_LEFT  = 2'd1;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] amount;
    logic [1:0]         turn;
  } v2d_item_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_scalar;
    logic               overflow;
  } v2d_res_t;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) begin
      return 16'sh7fff;
    end else if (v < -36'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic ovf16(input logic signed [35:0] v);
    return (v > 36'sd32767) || (v < -36'sd32768);
  endfunction

endpackage

/* src/v2d_if.sv */
// ----------------------------------------------------------------------------
// v2d_in_if / v2d_out_if
// Valid/ready channels carrying one item of the 2D vector unit.
// ----------------------------------------------------------------------------
interface v2d_in_if import v2d_pkg::*; ();
  logic      valid;
  logic      ready;
  v2d_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface v2d_out_if import v2d_pkg::*; ();
  logic     valid;
  logic     ready;
  v2d_res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/v2d_isqrt.sv */
// ----------------------------------------------------------------------------
// v2d_isqrt
// Pipelined floor integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module v2d_isqrt import v2d_pkg::*; #(
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_n,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [MAG_W-1:0]  out_root,
  output logic [TAG_W-1:0]  out_tag
);

  localparam int RW = SQ_W + 2;

  logic [ISQ_STEPS:0]  vld_r;
  logic [RW-1:0]       rem_r [ISQ_STEPS+1];
  logic [MAG_W-1:0]    root_r [ISQ_STEPS+1];
  logic [SQ_W-1:0]     n_r [ISQ_STEPS+1];
  logic [TAG_W-1:0]    tag_r [ISQ_STEPS+1];

  always_comb begin
    rem_r[0]  = '0;
    root_r[0] = '0;
    n_r[0]    = in_n;
    tag_r[0]  = in_tag;
    vld_r[0]  = in_valid;
  end

  for (genvar s = 0; s < ISQ_STEPS; s++) begin : g_st
    logic [RW-1:0]    rem_nxt;
    logic [RW-1:0]    trial;
    logic [MAG_W-1:0] root_nxt;
    always_comb begin
      rem_nxt  = {rem_r[s][RW-3:0], n_r[s][SQ_W-1-2*s -: 2]};
      trial    = {{(RW-MAG_W-2){1'b0}}, root_r[s], 2'b01};
      root_nxt = {root_r[s][MAG_W-2:0], 1'b0};
      if (rem_nxt >= trial) begin
        rem_nxt  = rem_nxt - trial;
        root_nxt = {root_r[s][MAG_W-2:0], 1'b1};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
      if (en) begin
        rem_r[s+1]  <= rem_nxt;
        root_r[s+1] <= root_nxt;
        n_r[s+1]    <= n_r[s];
        tag_r[s+1]  <= tag_r[s];
      end
    end
  end

  assign out_valid = vld_r[ISQ_STEPS];
  assign out_root  = root_r[ISQ_STEPS];
  assign out_tag   = tag_r[ISQ_STEPS];

endmodule

/* src/v2d_div.sv */
// ----------------------------------------------------------------------------
// v2d_div
// Pipelined restoring divider for |amount| / magnitude, one bit per stage.
// ----------------------------------------------------------------------------
module v2d_div import v2d_pkg::*; #(
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DIV_W-1:0]  in_num,
  input  logic [MAG_W-1:0]  in_den,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [DIV_W-1:0]  out_quo,
  output logic [TAG_W-1:0]  out_tag
);

  localparam int RW = MAG_W + 1;

  logic [DIV_W:0]     vld_r;
  logic [RW-1:0]      rem_r [DIV_W+1];
  logic [DIV_W-1:0]   num_r [DIV_W+1];
  logic [MAG_W-1:0]   den_r [DIV_W+1];
  logic [TAG_W-1:0]   tag_r [DIV_W+1];

  always_comb begin
    vld_r[0] = in_valid;
    rem_r[0] = '0;
    num_r[0] = in_num;
    den_r[0] = in_den;
    tag_r[0] = in_tag;
  end

  for (genvar s = 0; s < DIV_W; s++) begin : g_st
    logic [RW-1:0]    rem_nxt;
    logic [DIV_W-1:0] num_nxt;
    always_comb begin
      rem_nxt = {rem_r[s][RW-2:0], num_r[s][DIV_W-1]};
      num_nxt = {num_r[s][DIV_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, den_r[s]}) begin
        rem_nxt    = rem_nxt - {1'b0, den_r[s]};
        num_nxt[0] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
      if (en) begin
        rem_r[s+1] <= rem_nxt;
        num_r[s+1] <= num_nxt;
        den_r[s+1] <= den_r[s];
        tag_r[s+1] <= tag_r[s];
      end
    end
  end

  assign out_valid = vld_r[DIV_W];
  assign out_quo   = num_r[DIV_W];
  assign out_tag   = tag_r[DIV_W];

endmodule

/* src/int16_vector2d_alu_core.sv */
// ----------------------------------------------------------------------------
// int16_vector2d_alu_core
// Signed 16-bit 2D vector unit: magnitude, inner product, parallel,
// orthogonal, add and scalar multiply with saturation.
// ----------------------------------------------------------------------------
// One item per cycle sustained while the output is not held; two stages for the
// squares, sixteen for the bit-serial root pipeline, sixteen for the divider
// pipeline and three for operand select, products and saturating output register.
// The whole pipeline stalls together when the output is held.
module int16_vector2d_alu_core import v2d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  v2d_in_if.sink    in_ch,
  v2d_out_if.source out_ch
);

  localparam int TAG_W = $bits(v2d_item_t);

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: squares
  logic              s1_v_r;
  v2d_item_t         s1_d_r;
  logic [SQ_W-1:0]   s1_xx_r, s1_yy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_ch.valid;
    if (en) begin
      s1_d_r  <= in_ch.data;
      s1_xx_r <= SQ_W'($signed(in_ch.data.a_x) * $signed(in_ch.data.a_x));
      s1_yy_r <= SQ_W'($signed(in_ch.data.a_y) * $signed(in_ch.data.a_y));
    end
  end

  // stage 2: sum of squares
  logic              s2_v_r;
  v2d_item_t         s2_d_r;
  logic [SQ_W-1:0]   s2_sq_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
    if (en) begin
      s2_d_r  <= s1_d_r;
      s2_sq_r <= s1_xx_r + s1_yy_r;
    end
  end

  logic             sq_v;
  logic [MAG_W-1:0] sq_root;
  logic [TAG_W-1:0] sq_tag;
  v2d_isqrt #(.TAG_W(TAG_W)) u_isqrt (
    .clk, .rst_n, .en,
    .in_valid(s2_v_r), .in_n(s2_sq_r), .in_tag(s2_d_r),
    .out_valid(sq_v), .out_root(sq_root), .out_tag(sq_tag)
  );

  v2d_item_t sq_d;
  assign sq_d = v2d_item_t'(sq_tag);

  logic [DIV_W-1:0] amt_abs;
  logic [16:0]      amt_w;
  assign amt_w   = {sq_d.amount[15], sq_d.amount};
  assign amt_abs = DIV_W'(sq_d.amount[15] ? -amt_w : amt_w);

  localparam int DT_W = TAG_W + MAG_W;
  logic             dv_v;
  logic [DIV_W-1:0] dv_q;
  logic [DT_W-1:0]  dv_tag;
  v2d_div #(.TAG_W(DT_W)) u_div (
    .clk, .rst_n, .en,
    .in_valid(sq_v), .in_num(amt_abs),
    .in_den((sq_root == '0) ? MAG_W'(1) : sq_root),
    .in_tag({sq_tag, sq_root}),
    .out_valid(dv_v), .out_quo(dv_q), .out_tag(dv_tag)
  );

  v2d_item_t        dv_d;
  logic [MAG_W-1:0] dv_mag;
  assign dv_d   = v2d_item_t'(dv_tag[DT_W-1:MAG_W]);
  assign dv_mag = dv_tag[MAG_W-1:0];

  // stage A: operand select
  logic               sa_v_r;
  logic [2:0]         sa_op_r;
  logic               sa_zero_r;
  logic signed [17:0] sa_x0_r, sa_y0_r, sa_x1_r, sa_y1_r;
  logic signed [17:0] sa_m_r;
  logic [MAG_W-1:0]   sa_mag_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sa_v_r <= 1'b0;
    else if (en) sa_v_r <= dv_v;
    if (en) begin
      sa_op_r   <= dv_d.op;
      sa_mag_r  <= dv_mag;
      sa_zero_r <= 1'b0;
      sa_x0_r   <= 18'(dv_d.a_x);
      sa_y0_r   <= 18'(dv_d.a_y);
      sa_x1_r   <= 18'(dv_d.b_x);
      sa_y1_r   <= 18'(dv_d.b_y);
      sa_m_r    <= 18'(dv_d.amount);
      case (dv_d.op)
        OP_PAR, OP_ORT: begin
          sa_zero_r <= (dv_mag == '0) ||
                       ((dv_d.op == OP_ORT) && (dv_d.turn != TURN_RIGHT) &&
                        (dv_d.turn != TURN_LEFT));
          sa_m_r <= dv_d.amount[15] ? -$signed({2'b00, dv_q}) : $signed({2'b00, dv_q});
          if (dv_d.op == OP_ORT && dv_d.turn == TURN_RIGHT) begin
            sa_x0_r <= 18'(dv_d.a_y);
            sa_y0_r <= -18'(dv_d.a_x);
          end else if (dv_d.op == OP_ORT) begin
            sa_x0_r <= -18'(dv_d.a_y);
            sa_y0_r <= 18'(dv_d.a_x);
          end
        end
        default: ;
      endcase
    end
  end

  // stage B: products and sums
  logic               sb_v_r;
  logic [2:0]         sb_op_r;
  logic               sb_zero_r;
  logic signed [35:0] sb_px_r, sb_py_r, sb_ax_r, sb_ay_r;
  logic [MAG_W-1:0]   sb_mag_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sb_v_r <= 1'b0;
    else if (en) sb_v_r <= sa_v_r;
    if (en) begin
      sb_op_r   <= sa_op_r;
      sb_zero_r <= sa_zero_r;
      sb_mag_r  <= sa_mag_r;
      sb_ax_r   <= 36'(sa_x0_r + sa_x1_r);
      sb_ay_r   <= 36'(sa_y0_r + sa_y1_r);
      if (sa_op_r == OP_DOT) begin
        sb_px_r <= 36'(sa_x0_r * sa_x1_r);
        sb_py_r <= 36'(sa_y0_r * sa_y1_r);
      end else begin
        sb_px_r <= 36'(sa_x0_r * sa_m_r);
        sb_py_r <= 36'(sa_y0_r * sa_m_r);
      end
    end
  end

  // stage C: combine, saturate
  logic signed [35:0] dot_sum, dot_q;
  assign dot_sum = sb_px_r + sb_py_r;
  assign dot_q   = (dot_sum < 0) ? -((-dot_sum) >>> FRAC_BITS) : (dot_sum >>> FRAC_BITS);

  v2d_res_t res_nxt;
  always_comb begin
    res_nxt = '0;
    case (sb_op_r)
      OP_MAG: begin
        res_nxt.out_scalar = sat16(36'(sb_mag_r));
        res_nxt.overflow   = ovf16(36'(sb_mag_r));
      end
      OP_DOT: begin
        res_nxt.out_scalar = sat16(dot_q);
        res_nxt.overflow   = ovf16(dot_q);
      end
      OP_PAR, OP_ORT, OP_MUL: begin
        if (!sb_zero_r) begin
          res_nxt.out_x    = sat16(sb_px_r);
          res_nxt.out_y    = sat16(sb_py_r);
          res_nxt.overflow = ovf16(sb_px_r) || ovf16(sb_py_r);
        end
      end
      OP_ADD: begin
        res_nxt.out_x    = sat16(sb_ax_r);
        res_nxt.out_y    = sat16(sb_ay_r);
        res_nxt.overflow = ovf16(sb_ax_r) || ovf16(sb_ay_r);
      end
      default: ;
    endcase
  end

  logic     out_v_r;
  v2d_res_t out_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= sb_v_r;
    if (en) out_d_r <= res_nxt;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

endmodule

/* dv/int16_vector2d_alu_core_tb.sv */
// ----------------------------------------------------------------------------
// int16_vector2d_alu_core_tb
// Self-checking testbench for the 2D vector unit. A directed set covers
// saturation, zero vectors, turn codes and unused operations; random items
// follow over phases of sender idling and receiver stalling, including a long
// output hold and a full drain. Every result is checked against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module int16_vector2d_alu_core_tb;
  import v2d_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam logic [1:0] TURN_NULL_A = 2'd2;
  localparam logic [1:0] TURN_NULL_B = 2'd3;
  localparam int FRAC = 8;
  localparam int LATENCY = 37;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS = 1600;
  localparam int HOLD_CYCLES = 300;

  class vec_scoreboard;
    v2d_res_t expq[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    static function longint clamp16(longint v, ref bit ov);
      if (v > 32767) begin
        ov = 1;
        return 32767;
      end
      if (v < -32768) begin
        ov = 1;
        return -32768;
      end
      return v;
    endfunction

    static function longint root_floor(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 32;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return longint'(res);
    endfunction

    function void note_input(v2d_item_t it);
      longint ax, ay, bx, by, amt, mag, q, vx, vy, rx, ry, rs;
      bit ov;
      v2d_res_t r;
      ax = longint'(it.a_x); ay = longint'(it.a_y);
      bx = longint'(it.b_x); by = longint'(it.b_y);
      amt = longint'(it.amount);
      rx = 0; ry = 0; rs = 0; ov = 0;
      mag = root_floor(longint'(ax * ax + ay * ay));
      case (it.op)
        OP_MAG: rs = clamp16(mag, ov);
        OP_DOT: rs = clamp16((ax * bx + ay * by) / (64'sd1 <<< FRAC), ov);
        OP_PAR: if (mag != 0) begin
          q = amt / mag;
          rx = clamp16(ax * q, ov);
          ry = clamp16(ay * q, ov);
        end
        OP_ORT: if (mag != 0) begin
          q = amt / mag;
          vx = 0; vy = 0;
          if (it.turn == TURN_RIGHT) begin
            vx = ay; vy = -ax;
          end else if (it.turn == TURN_LEFT) begin
            vx = -ay; vy = ax;
          end
          rx = clamp16(vx * q, ov);
          ry = clamp16(vy * q, ov);
        end
        OP_ADD: begin
          rx = clamp16(ax + bx, ov);
          ry = clamp16(ay + by, ov);
        end
        OP_MUL: begin
          rx = clamp16(ax * amt, ov);
          ry = clamp16(ay * amt, ov);
        end
        default: ;
      endcase
      r.out_x = rx[15:0];
      r.out_y = ry[15:0];
      r.out_scalar = rs[15:0];
      r.overflow = ov;
      expq.push_back(r);
    endfunction

    function void check_result(v2d_res_t got);
      v2d_res_t e;
      if (expq.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = expq.pop_front();
      if (got.out_x !== e.out_x) begin
        $display("%0t: out_x expected %0d actual %0d", $time, e.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== e.out_y) begin
        $display("%0t: out_y expected %0d actual %0d", $time, e.out_y, got.out_y);
        errors++;
      end
      if (got.out_scalar !== e.out_scalar) begin
        $display("%0t: out_scalar expected %0d actual %0d", $time, e.out_scalar,
                 got.out_scalar);
        errors++;
      end
      if (got.overflow !== e.overflow) begin
        $display("%0t: overflow expected %0b actual %0b", $time, e.overflow,
                 got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  v2d_in_if in_ch();
  v2d_out_if out_ch();

  int16_vector2d_alu_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  vec_scoreboard sb = new();
  int idle_pct;
  int stall_pct;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  longint cycles = 0;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("int16_vector2d_alu_core_tb failed");
      $finish;
    end
  end

  // result side: check, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic signed [15:0] pick_word();
    logic signed [15:0] w;
    case ($urandom_range(3))
      0: w = 16'($urandom);
      1: w = 16'($signed($urandom_range(127)) - 64);
      2: case ($urandom_range(5))
           0: w = -16'sd32768;
           1: w = -16'sd32767;
           2: w = -16'sd1;
           3: w = 16'sd0;
           4: w = 16'sd1;
           default: w = 16'sd32767;
         endcase
      default: w = 16'($signed($urandom_range(4095)) - 2048);
    endcase
    return w;
  endfunction

  function automatic v2d_item_t pick_item();
    v2d_item_t it;
    it.op = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
    it.a_x = pick_word();
    it.a_y = pick_word();
    it.b_x = pick_word();
    it.b_y = pick_word();
    it.amount = pick_word();
    it.turn = ($urandom_range(4) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1));
    return it;
  endfunction

  function automatic v2d_item_t mk(logic [2:0] op, int ax, int ay, int bx, int by,
                                   int amt, logic [1:0] turn);
    v2d_item_t it;
    it.op = op; it.a_x = 16'(ax); it.a_y = 16'(ay); it.b_x = 16'(bx);
    it.b_y = 16'(by); it.amount = 16'(amt); it.turn = turn;
    return it;
  endfunction

  task automatic send_item(v2d_item_t it);
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(4) + 1;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expq.size() != 0) @(posedge clk);
  endtask

  initial begin
    v2d_item_t dir[$];
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir.push_back(mk(OP_MAG, 32767, 32767, 0, 0, 0, TURN_RIGHT));
    dir.push_back(mk(OP_MAG, -32768, -32768, 0, 0, 0, TURN_RIGHT));
    dir.push_back(mk(OP_MAG, 3, -4, 0, 0, 0, TURN_RIGHT));
    dir.push_back(mk(OP_MAG, 0, 0, 0, 0, 0, TURN_RIGHT));
    dir.push_back(mk(OP_DOT, 32767, 32767, 32767, 32767, 0, TURN_RIGHT));
    dir.push_back(mk(OP_DOT, -32768, -32768, 32767, 32767, 0, TURN_RIGHT));
    dir.push_back(mk(OP_DOT, -3, 1, 100, -1, 0, TURN_RIGHT));
    dir.push_back(mk(OP_PAR, 0, 0, 0, 0, 1000, TURN_RIGHT));
    dir.push_back(mk(OP_PAR, 3, 4, 0, 0, 100, TURN_RIGHT));
    dir.push_back(mk(OP_PAR, 1, 0, 0, 0, -32768, TURN_RIGHT));
    dir.push_back(mk(OP_PAR, -1, 1, 0, 0, 32767, TURN_RIGHT));
    dir.push_back(mk(OP_PAR, -32768, 0, 0, 0, 32767, TURN_RIGHT));
    dir.push_back(mk(OP_ORT, 0, 0, 0, 0, 500, TURN_LEFT));
    dir.push_back(mk(OP_ORT, 3, 4, 0, 0, 50, TURN_RIGHT));
    dir.push_back(mk(OP_ORT, 3, 4, 0, 0, 50, TURN_LEFT));
    dir.push_back(mk(OP_ORT, 3, 4, 0, 0, 50, TURN_NULL_A));
    dir.push_back(mk(OP_ORT, 3, 4, 0, 0, 50, TURN_NULL_B));
    dir.push_back(mk(OP_ORT, -32768, 0, 0, 0, -32768, TURN_RIGHT));
    dir.push_back(mk(OP_ORT, -32768, 0, 0, 0, -32768, TURN_LEFT));
    dir.push_back(mk(OP_ADD, 32767, -32768, 1, -1, 0, TURN_RIGHT));
    dir.push_back(mk(OP_ADD, -5, 7, 3, -2, 0, TURN_RIGHT));
    dir.push_back(mk(OP_MUL, -32768, 32767, 0, 0, -32768, TURN_RIGHT));
    dir.push_back(mk(OP_MUL, 100, -3, 0, 0, 7, TURN_RIGHT));
    dir.push_back(mk(OP_SPARE_A, 1234, -1, 5, 6, 7, TURN_LEFT));
    dir.push_back(mk(OP_SPARE_B, -1, 1234, 5, 6, 7, TURN_RIGHT));
    foreach (dir[i]) send_item(dir[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      for (int n = 0; n < RAND_ITEMS / 4; n++) begin
        if (ph == 0 && n == 100) hold_reqs++;
        if (ph == 2 && n == 200) drain();
        send_item(pick_item());
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.expq.size() != 0) @(posedge clk);
    repeat (LATENCY * 3) @(posedge clk);
    if (sb.expq.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.expq.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("int16_vector2d_alu_core_tb passed");
    end else begin
      $display("int16_vector2d_alu_core_tb failed");
    end
    $finish;
  end

endmodule
